[sv/tds_pkg.sv]
// tds_pkg: shared constants, codes and controller/datapath bundles
// for the token dictionary substituter; no dependencies
package tds_pkg;

  localparam int unsigned DICT_ENTRIES = 128;
  localparam int unsigned KEY_CHARS    = 15;
  localparam int unsigned VALUE_CHARS  = 20;
  localparam int unsigned TOK_MAX      = KEY_CHARS - 1;

  localparam int unsigned ENT_W = $clog2(DICT_ENTRIES);
  localparam int unsigned IDX_W = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned LEN_W = $clog2(TOK_MAX + 1);
  localparam int unsigned TIX_W = $clog2(TOK_MAX);
  localparam int unsigned CNT_W = 5;
  localparam int unsigned KROW_W = 8 * KEY_CHARS;
  localparam int unsigned VROW_W = 8 * VALUE_CHARS;

  // operation codes
  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_KEY  = 2'd2;
  localparam logic [1:0] OP_VAL  = 2'd3;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [1:0] {
    SEL_VALUE = 2'd0,
    SEL_TOKEN = 2'd1,
    SEL_SPACE = 2'd2,
    SEL_CHAR  = 2'd3
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      clr_row;
    logic      scan_start;
    logic      scan_run;
    logic      val_read;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    logic      len_clr;
  } tds_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_flush;
    logic ovf;
    logic len_zero;
    logic len_full;
    logic clr_done;
    logic hit;
    logic miss;
    logic val_end;
    logic tok_last;
    logic out_free;
  } tds_sts_t;

endpackage

[sv/tds_in_if.sv]
// tds_in_if: input channel, valid/ready plus one input item
// depends on nothing
interface tds_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_byte;
  logic [6:0] entry;
  logic [4:0] position;

  modport source (output valid, operation, char_byte, entry, position, input ready);
  modport sink   (input valid, operation, char_byte, entry, position, output ready);
endinterface

[sv/tds_out_if.sv]
// tds_out_if: output channel, valid/ready plus one result byte
// depends on nothing
interface tds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

[sv/tds_ctrl.sv]
// tds_ctrl: sequencer for clearing, dictionary scan and byte emission
// depends on tds_pkg
module tds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tds_pkg::tds_sts_t sts_i,
  output tds_pkg::tds_cmd_t cmd_o
);
  import tds_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_VRD  = 3'd3;
  localparam logic [2:0] S_EMV  = 3'd4;
  localparam logic [2:0] S_TOK  = 3'd5;
  localparam logic [2:0] S_SP   = 3'd6;
  localparam logic [2:0] S_CH   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_sel = SEL_VALUE;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_row = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_load) begin
            state_d = S_IDLE;
          end else if (sts_i.is_flush) begin
            if (sts_i.ovf) begin
              state_d = S_SP;
            end else if (!sts_i.len_zero) begin
              cmd_o.scan_start = 1'b1;
              state_d = S_SCAN;
            end
          end else if (sts_i.ovf) begin
            state_d = S_CH;
          end else if (sts_i.len_full) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_TOK;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          state_d = S_VRD;
        end else if (sts_i.miss) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = S_TOK;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      S_VRD: begin
        cmd_o.val_read = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        state_d = S_EMV;
      end
      S_EMV: begin
        if (sts_i.out_free) begin
          if (sts_i.val_end) begin
            state_d = S_SP;
          end else begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = SEL_VALUE;
            cmd_o.cnt_inc  = 1'b1;
          end
        end
      end
      S_TOK: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = SEL_TOKEN;
          cmd_o.cnt_inc  = 1'b1;
          if (sts_i.tok_last) state_d = sts_i.ovf ? S_CH : S_SP;
        end
      end
      S_SP: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_SPACE;
          cmd_o.emit_last = 1'b1;
          cmd_o.len_clr   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CH: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_CHAR;
          cmd_o.emit_last = 1'b1;
          cmd_o.len_clr   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else         state_q <= state_d;
  end

endmodule

[sv/tds_dp.sv]
// tds_dp: dictionary memories, token buffer, key compare and output register
// depends on tds_pkg
module tds_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        char_byte_i,
  input  logic [6:0]        entry_i,
  input  logic [4:0]        position_i,
  input  tds_pkg::tds_cmd_t cmd_i,
  output tds_pkg::tds_sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import tds_pkg::*;

  logic [KROW_W-1:0] key_mem [DICT_ENTRIES];
  logic [VROW_W-1:0] val_mem [DICT_ENTRIES];
  logic [KROW_W-1:0] key_rd_q;
  logic [VROW_W-1:0] val_rd_q;

  logic [7:0]       tok_buf_q [TOK_MAX];
  logic [LEN_W-1:0] len_q;
  logic             ovf_q;
  logic [7:0]       ch_q;
  logic [IDX_W-1:0] idx_q;
  logic [ENT_W-1:0] rd_idx_q;
  logic             rd_v_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic is_load, is_flush, is_text, ent_ok, key_ok, val_ok, match;
  logic [7:0] val_byte, tok_byte, emit_byte;

  // input decode
  assign is_load  = (operation_i == OP_KEY) || (operation_i == OP_VAL);
  assign is_flush = (operation_i == OP_END) ||
                    ((operation_i == OP_TEXT) &&
                     ((char_byte_i == 8'h00) || (char_byte_i == SPACE_BYTE)));
  assign is_text  = !is_load && !is_flush;
  assign ent_ok   = {{(IDX_W-7){1'b0}}, entry_i} < IDX_W'(DICT_ENTRIES);
  assign key_ok   = ent_ok && (position_i < CNT_W'(KEY_CHARS));
  assign val_ok   = ent_ok && (position_i < CNT_W'(VALUE_CHARS));

  // key compare against the buffered token, all positions in parallel
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (i < TOK_MAX && LEN_W'(i) < len_q) begin
        if (key_rd_q[8*i +: 8] != tok_buf_q[i]) match = 1'b0;
      end else if (LEN_W'(i) == len_q) begin
        if (key_rd_q[8*i +: 8] != 8'h00) match = 1'b0;
      end
    end
  end

  assign val_byte = val_rd_q[8*cnt_q +: 8];
  assign tok_byte = tok_buf_q[cnt_q[TIX_W-1:0]];

  always_comb begin
    case (cmd_i.emit_sel)
      SEL_VALUE: emit_byte = val_byte;
      SEL_TOKEN: emit_byte = tok_byte;
      SEL_SPACE: emit_byte = SPACE_BYTE;
      SEL_CHAR:  emit_byte = ch_q;
      default:   emit_byte = SPACE_BYTE;
    endcase
  end

  // status to the controller
  always_comb begin
    sts_o.is_load  = is_load;
    sts_o.is_flush = is_flush;
    sts_o.ovf      = ovf_q;
    sts_o.len_zero = (len_q == '0);
    sts_o.len_full = (len_q == LEN_W'(TOK_MAX));
    sts_o.clr_done = (idx_q == IDX_W'(DICT_ENTRIES - 1));
    sts_o.hit      = rd_v_q && match;
    sts_o.miss     = rd_v_q && !match && (rd_idx_q == ENT_W'(DICT_ENTRIES - 1));
    sts_o.val_end  = (val_byte == 8'h00) || (cnt_q == CNT_W'(VALUE_CHARS - 1));
    sts_o.tok_last = ({{(CNT_W-LEN_W){1'b0}}, len_q} == cnt_q + CNT_W'(1));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // dictionary memories: clearing pass, loads, registered scan reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_row) begin
      key_mem[idx_q[ENT_W-1:0]] <= '0;
      val_mem[idx_q[ENT_W-1:0]] <= '0;
    end else if (cmd_i.accept && operation_i == OP_KEY && key_ok) begin
      key_mem[entry_i[ENT_W-1:0]][8*position_i +: 8] <= char_byte_i;
    end else if (cmd_i.accept && operation_i == OP_VAL && val_ok) begin
      val_mem[entry_i[ENT_W-1:0]][8*position_i +: 8] <= char_byte_i;
    end
    if (cmd_i.scan_run) key_rd_q <= key_mem[idx_q[ENT_W-1:0]];
    if (cmd_i.val_read) val_rd_q <= val_mem[rd_idx_q];
  end

  // token buffer and latched character
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_text && !ovf_q && len_q != LEN_W'(TOK_MAX))
      tok_buf_q[len_q[TIX_W-1:0]] <= char_byte_i;
    if (cmd_i.accept) ch_q <= char_byte_i;
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= cmd_i.emit_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      rd_v_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && is_flush) begin
        ovf_q <= 1'b0;
        if (ovf_q) len_q <= '0;
      end else if (cmd_i.accept && is_text && !ovf_q) begin
        if (len_q == LEN_W'(TOK_MAX)) ovf_q <= 1'b1;
        else                          len_q <= len_q + LEN_W'(1);
      end else if (cmd_i.len_clr) begin
        len_q <= '0;
      end

      if (cmd_i.clr_row) idx_q <= idx_q + IDX_W'(1);
      else if (cmd_i.scan_start) idx_q <= '0;
      else if (cmd_i.scan_run && idx_q < IDX_W'(DICT_ENTRIES)) idx_q <= idx_q + IDX_W'(1);

      rd_v_q <= cmd_i.scan_run && (idx_q < IDX_W'(DICT_ENTRIES));
      if (cmd_i.scan_run) rd_idx_q <= idx_q[ENT_W-1:0];

      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + CNT_W'(1);

      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

[sv/token_dictionary_substituter.sv]
// Token dictionary substituter top level: controller plus datapath.
// Reset starts a clearing pass over the 128 entries of both dictionary
// memories; no transaction is taken until it ends. A token end with a buffered,
// not overflowed token scans the dictionary one entry per cycle, then emits
// one byte a cycle while the output is not stalled.
// depends on tds_pkg, tds_in_if, tds_out_if, tds_ctrl, tds_dp
module token_dictionary_substituter (
  input  logic  clk_i,
  input  logic  rst_ni,
  tds_in_if.sink    in_i,
  tds_out_if.source out_o
);
  import tds_pkg::*;

  tds_cmd_t cmd;
  tds_sts_t sts;

  tds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tds_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (in_i.operation),
    .char_byte_i (in_i.char_byte),
    .entry_i     (in_i.entry),
    .position_i  (in_i.position),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last_of_run)
  );

endmodule

[sv/tds_checker.sv]
// tds_checker: port-level assertions for the substituter, with its bind
// depends on token_dictionary_substituter and tds_pkg
module tds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import tds_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

  // a dictionary load produces no output
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == OP_KEY || in_op == OP_VAL) && !out_valid
    |=> !out_valid)
    else $error("load produced output");

  // output only starts from a busy sequencer
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output started while idle");

endmodule

bind token_dictionary_substituter tds_checker u_tds_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_op     (in_i.operation),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.out_byte),
  .out_last  (out_o.last_of_run)
);
